FILE: src/ihr_pkg.sv
// ----------------------------------------------------------------------------
// ihr_pkg
// Shared types and constants for the IPv4 receive header check.
// ----------------------------------------------------------------------------
package ihr_pkg;

  // Defaults for top-level parameters
  localparam int PROTO_SLOTS_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Header field constants
  localparam logic [3:0]  IPV4_VERSION = 4'd4;
  localparam logic [3:0]  MIN_IHL      = 4'd5;
  localparam logic [15:0] CHECKSUM_OK  = 16'hFFFF;
  localparam int          FLAG_MF_BIT  = 13;
  localparam int          FRAG_OFS_W   = 13;

  // Word positions within the header
  localparam logic [4:0] WORD_VER_IHL   = 5'd0;
  localparam logic [4:0] WORD_FRAG      = 5'd3;
  localparam logic [4:0] WORD_PROTO     = 5'd4;
  localparam logic [4:0] WORD_SRC_HI    = 5'd6;
  localparam logic [4:0] WORD_SRC_LO    = 5'd7;
  localparam logic [4:0] WORD_DST_HI    = 5'd8;
  localparam logic [4:0] WORD_DST_LO    = 5'd9;
  localparam logic [4:0] WORDS_MIN_HDR  = 5'd10;

  // Configuration register indexes
  localparam logic [2:0] CFG_LOCAL_ADDR_0     = 3'd0;
  localparam logic [2:0] CFG_LOCAL_ADDR_1     = 3'd1;
  localparam logic [2:0] CFG_LOCAL_ADDR_EN    = 3'd2;
  localparam logic [2:0] CFG_PROTO_CODES      = 3'd3;
  localparam logic [2:0] CFG_PROTO_SLOT_VALID = 3'd4;

  // Packet verdict codes
  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_VERSION   = 3'd2,
    VERDICT_HDR_LEN   = 3'd3,
    VERDICT_CHECKSUM  = 3'd4,
    VERDICT_NOT_LOCAL = 3'd5,
    VERDICT_FRAGMENT  = 3'd6,
    VERDICT_UNK_PROTO = 3'd7
  } verdict_t;

  // What the front end decided about a packet
  typedef enum logic [1:0] {
    KIND_SHORT   = 2'd0,
    KIND_VERSION = 2'd1,
    KIND_HDR_LEN = 2'd2,
    KIND_FULL    = 2'd3
  } kind_t;

  // Captured header, handed from front to back through the queue
  typedef struct packed {
    kind_t        kind;
    logic [20:0]  sum;
    logic [3:0]   ihl;
    logic [15:0]  frag;
    logic [7:0]   proto;
    logic [31:0]  src;
    logic [31:0]  dst;
  } hdr_rec_t;

  // Configuration registers seen by the back end
  typedef struct packed {
    logic [31:0] local_addr_0;
    logic [31:0] local_addr_1;
    logic [1:0]  local_addr_en;
    logic [63:0] proto_codes;
    logic [7:0]  proto_slot_valid;
  } cfg_t;

  // Queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // One result word
  typedef struct packed {
    logic [31:0] dest_addr;
    logic [31:0] source_addr;
    logic [5:0]  header_bytes;
    logic [7:0]  protocol;
    logic [2:0]  matched_slot;
    verdict_t    verdict;
  } result_t;

endpackage

FILE: src/ipv4_rx_header_check.sv
// ----------------------------------------------------------------------------
// ipv4_rx_header_check
// IPv4 receive header check: one verdict word per received packet.
// ----------------------------------------------------------------------------
// Packet words are taken at one word per clock with no gaps of its own: each
// header word adds into the header sum and captures its field in the front
// end in the cycle it arrives. A packet's verdict is queued on the word that
// completes the header (or on the last word of a short packet) and moves on
// into the output register, which drives the result channel, when free. The
// input stalls only while the verdict queue (QUEUE_DEPTH entries) is full,
// i.e. when the sink has held off QUEUE_DEPTH + 1 verdicts (the queue plus
// the output register). Configuration writes are always accepted and must
// only be made while no packet is in flight and no verdict is pending.
// ----------------------------------------------------------------------------
module ipv4_rx_header_check #(
  parameter int PROTO_SLOTS = ihr_pkg::PROTO_SLOTS_DEF,
  parameter int QUEUE_DEPTH = ihr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Packet words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] data_word
  input  logic        in_tuser,   // [0] packet_start
  input  logic        in_tlast,   // packet_end
  // Verdict words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // [2:0] verdict, [5:3] matched_slot,
                                  // [13:6] protocol, [19:14] header_bytes,
                                  // [51:20] source_addr, [83:52] dest_addr,
                                  // [87:84] zero
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import ihr_pkg::*;

  cfg_t      cfg_r;
  hdr_rec_t  push_rec;
  hdr_rec_t  head_rec;
  q_stat_t   q_stat;
  result_t   res;
  logic      q_push;
  logic      q_pop;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_stat.full;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOCAL_ADDR_0:     cfg_r.local_addr_0     <= cfg_data[31:0];
        CFG_LOCAL_ADDR_1:     cfg_r.local_addr_1     <= cfg_data[31:0];
        CFG_LOCAL_ADDR_EN:    cfg_r.local_addr_en    <= cfg_data[1:0];
        CFG_PROTO_CODES:      cfg_r.proto_codes      <= cfg_data;
        CFG_PROTO_SLOT_VALID: cfg_r.proto_slot_valid <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ihr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_word  (in_tdata),
    .in_start (in_tuser),
    .in_end   (in_tlast),
    .push     (q_push),
    .rec      (push_rec)
  );

  ihr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  ihr_back #(
    .PROTO_SLOTS (PROTO_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (!q_stat.empty),
    .head_rec   (head_rec),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  // Pack the verdict word
  assign out_tdata = {4'b0000, res.dest_addr, res.source_addr, res.header_bytes,
                      res.protocol, res.matched_slot, res.verdict};

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("verdict queue overflow");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("verdict queue underflow");

  // A slot is reported only with an accept verdict
  a_slot_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (res.verdict != VERDICT_ACCEPT)) |-> (res.matched_slot == 3'd0))
    else $error("matched slot set on a rejected packet");

endmodule

FILE: src/ihr_front.sv
// ----------------------------------------------------------------------------
// ihr_front
// Takes packet words, sums the header and captures its fields, and decides
// when a packet needs a verdict and of which kind.
// ----------------------------------------------------------------------------
module ihr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [15:0]      in_word,
  input  logic             in_start,
  input  logic             in_end,
  output logic             push,
  output ihr_pkg::hdr_rec_t rec
);
  import ihr_pkg::*;

  logic [4:0]  word_count_r, word_count_nxt;
  logic [20:0] sum_r, sum_nxt;
  logic [7:0]  ver_ihl_r, ver_ihl_nxt;
  logic [15:0] frag_r, frag_nxt;
  logic [7:0]  proto_r, proto_nxt;
  logic [31:0] src_r, src_nxt;
  logic [31:0] dst_r, dst_nxt;
  logic        sent_r, sent_nxt;

  logic [4:0]  n_b;
  logic [20:0] sum_b;
  logic [7:0]  ver_b;
  logic [15:0] frag_b;
  logic [7:0]  proto_b;
  logic [31:0] src_b;
  logic [31:0] dst_b;
  logic        sent_b;
  logic [4:0]  hwords;
  logic        bad_hdr;
  logic        emit;
  kind_t       kind;
  logic        accept;

  assign accept = in_valid & in_ready;

  // Capture fields and decide on a verdict for this word
  always_comb begin
    n_b     = in_start ? '0 : word_count_r;
    sum_b   = in_start ? '0 : sum_r;
    ver_b   = in_start ? '0 : ver_ihl_r;
    frag_b  = in_start ? '0 : frag_r;
    proto_b = in_start ? '0 : proto_r;
    src_b   = in_start ? '0 : src_r;
    dst_b   = in_start ? '0 : dst_r;
    sent_b  = in_start ? 1'b0 : sent_r;

    ver_ihl_nxt = ver_b;
    frag_nxt    = frag_b;
    proto_nxt   = proto_b;
    src_nxt     = src_b;
    dst_nxt     = dst_b;
    sum_nxt     = sum_b;

    if (!sent_b) begin
      case (n_b)
        WORD_VER_IHL: ver_ihl_nxt = in_word[15:8];
        WORD_FRAG:    frag_nxt    = in_word;
        WORD_PROTO:   proto_nxt   = in_word[7:0];
        WORD_SRC_HI:  src_nxt     = {in_word, src_b[15:0]};
        WORD_SRC_LO:  src_nxt     = {src_b[31:16], in_word};
        WORD_DST_HI:  dst_nxt     = {in_word, dst_b[15:0]};
        WORD_DST_LO:  dst_nxt     = {dst_b[31:16], in_word};
        default: ;
      endcase
    end

    hwords = {ver_ihl_nxt[3:0], 1'b0};
    if (!sent_b && (n_b < hwords)) begin
      sum_nxt = sum_b + 21'(in_word);
    end

    word_count_nxt = (n_b == '1) ? n_b : n_b + 5'd1;

    bad_hdr = (ver_ihl_nxt[7:4] != IPV4_VERSION) || (ver_ihl_nxt[3:0] < MIN_IHL);
    emit    = 1'b0;
    kind    = KIND_SHORT;
    if (!sent_b) begin
      if (bad_hdr) begin
        if (word_count_nxt == WORDS_MIN_HDR) begin
          emit = 1'b1;
          kind = (ver_ihl_nxt[7:4] != IPV4_VERSION) ? KIND_VERSION : KIND_HDR_LEN;
        end
      end else if (word_count_nxt == hwords) begin
        emit = 1'b1;
        kind = KIND_FULL;
      end
      if (!emit && in_end) begin
        emit = 1'b1;
        kind = KIND_SHORT;
      end
    end
    sent_nxt = sent_b | emit;
  end

  assign push      = accept & emit;
  assign rec.kind  = kind;
  assign rec.sum   = sum_nxt;
  assign rec.ihl   = ver_ihl_nxt[3:0];
  assign rec.frag  = frag_nxt;
  assign rec.proto = proto_nxt;
  assign rec.src   = src_nxt;
  assign rec.dst   = dst_nxt;

  // Advance packet state; drop it all on the last word
  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_end)) begin
      word_count_r <= '0;
      sum_r        <= '0;
      ver_ihl_r    <= '0;
      frag_r       <= '0;
      proto_r      <= '0;
      src_r        <= '0;
      dst_r        <= '0;
      sent_r       <= 1'b0;
    end else if (accept) begin
      word_count_r <= word_count_nxt;
      sum_r        <= sum_nxt;
      ver_ihl_r    <= ver_ihl_nxt;
      frag_r       <= frag_nxt;
      proto_r      <= proto_nxt;
      src_r        <= src_nxt;
      dst_r        <= dst_nxt;
      sent_r       <= sent_nxt;
    end
  end

endmodule

FILE: src/ihr_queue.sv
// ----------------------------------------------------------------------------
// ihr_queue
// Short queue of captured headers between the front and back ends.
// ----------------------------------------------------------------------------
module ihr_queue #(
  parameter int DEPTH = ihr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ihr_pkg::hdr_rec_t push_rec,
  input  logic              pop,
  output ihr_pkg::hdr_rec_t head_rec,
  output ihr_pkg::q_stat_t  stat
);
  import ihr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  hdr_rec_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_rec   = mem[rd_ptr_r];

  // Wrap pointers and track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: src/ihr_back.sv
// ----------------------------------------------------------------------------
// ihr_back
// Folds the header checksum, checks destination, fragment and protocol,
// and holds the finished verdict word until the sink takes it.
// ----------------------------------------------------------------------------
module ihr_back #(
  parameter int PROTO_SLOTS = ihr_pkg::PROTO_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ihr_pkg::cfg_t     cfg,
  input  logic              head_valid,
  input  ihr_pkg::hdr_rec_t head_rec,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ihr_pkg::result_t  out_res
);
  import ihr_pkg::*;

  logic        out_valid_r;
  result_t     res_r, res_nxt;
  logic [16:0] fold1;
  logic [15:0] fold2;
  logic        chk_ok;
  logic        is_local;
  logic        is_frag;
  logic        slot_hit;
  logic [2:0]  slot;
  verdict_t    verdict;

  // Fold the sum twice and run the checks in priority order
  always_comb begin
    fold1    = {1'b0, head_rec.sum[15:0]} + 17'(head_rec.sum[20:16]);
    fold2    = fold1[15:0] + 16'(fold1[16]);
    chk_ok   = (fold2 == CHECKSUM_OK);
    is_local = (cfg.local_addr_en[0] && (head_rec.dst == cfg.local_addr_0)) ||
               (cfg.local_addr_en[1] && (head_rec.dst == cfg.local_addr_1));
    is_frag  = head_rec.frag[FLAG_MF_BIT] || (head_rec.frag[FRAG_OFS_W-1:0] != '0);

    // Lowest registered slot wins: scan from the top down
    slot_hit = 1'b0;
    slot     = '0;
    for (int i = PROTO_SLOTS - 1; i >= 0; i--) begin
      if (cfg.proto_slot_valid[i] && (cfg.proto_codes[8*i +: 8] == head_rec.proto)) begin
        slot_hit = 1'b1;
        slot     = 3'(i);
      end
    end

    verdict = VERDICT_ACCEPT;
    unique case (head_rec.kind)
      KIND_SHORT:   verdict = VERDICT_SHORT;
      KIND_VERSION: verdict = VERDICT_VERSION;
      KIND_HDR_LEN: verdict = VERDICT_HDR_LEN;
      KIND_FULL: begin
        priority if (!chk_ok)   verdict = VERDICT_CHECKSUM;
        else if (!is_local)     verdict = VERDICT_NOT_LOCAL;
        else if (is_frag)       verdict = VERDICT_FRAGMENT;
        else if (!slot_hit)     verdict = VERDICT_UNK_PROTO;
        else                    verdict = VERDICT_ACCEPT;
      end
    endcase

    res_nxt.verdict      = verdict;
    res_nxt.matched_slot = (verdict == VERDICT_ACCEPT) ? slot : 3'd0;
    res_nxt.protocol     = head_rec.proto;
    res_nxt.header_bytes = {head_rec.ihl, 2'b00};
    res_nxt.source_addr  = head_rec.src;
    res_nxt.dest_addr    = head_rec.dst;
  end

  assign pop       = head_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  // Hold the verdict word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the IPv4 receive header check. Packets are built
// with valid, broken and truncated headers, streamed in with random gaps
// while the verdict sink stalls at random, and every verdict word is compared
// field by field against a cycle-free prediction of the header check.
// ----------------------------------------------------------------------------
module tb;
  import ihr_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int SETTLE_WAIT = 16;

  // --------------------------------------------------------------------------
  // Header check prediction and verdict scoreboard
  // --------------------------------------------------------------------------
  class header_scoreboard;
    // configuration copy
    logic [31:0] addr0, addr1;
    logic [1:0]  addr_en;
    logic [63:0] codes;
    logic [7:0]  slot_valid;
    // packet state
    logic [4:0]  word_cnt;
    logic [20:0] hdr_sum;
    logic [7:0]  ver_ihl;
    logic [15:0] frag;
    logic [7:0]  proto;
    logic [31:0] src, dst;
    bit          decided;
    result_t     expected_verdicts[$];
    int          mismatches;

    function new();
      addr0 = '0; addr1 = '0; addr_en = '0; codes = '0; slot_valid = '0;
      mismatches = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      word_cnt = '0; hdr_sum = '0; ver_ihl = '0; frag = '0; proto = '0;
      src = '0; dst = '0; decided = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        CFG_LOCAL_ADDR_0:     addr0 = data[31:0];
        CFG_LOCAL_ADDR_1:     addr1 = data[31:0];
        CFG_LOCAL_ADDR_EN:    addr_en = data[1:0];
        CFG_PROTO_CODES:      codes = data;
        CFG_PROTO_SLOT_VALID: slot_valid = data[7:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // Full check of a complete, well-formed header
    function verdict_t header_verdict(output logic [2:0] slot);
      int unsigned s;
      s = hdr_sum;
      s = (s & 32'hFFFF) + (s >> 16);
      s = (s & 32'hFFFF) + (s >> 16);
      slot = '0;
      if (s != CHECKSUM_OK) return VERDICT_CHECKSUM;
      if (!((addr_en[0] && dst == addr0) || (addr_en[1] && dst == addr1)))
        return VERDICT_NOT_LOCAL;
      if (frag[FLAG_MF_BIT] || frag[FRAG_OFS_W-1:0] != '0) return VERDICT_FRAGMENT;
      for (int i = 0; i < 8; i++) begin
        if (slot_valid[i] && codes[8*i +: 8] == proto) begin
          slot = 3'(i);
          return VERDICT_ACCEPT;
        end
      end
      return VERDICT_UNK_PROTO;
    endfunction

    // Advance the packet state by one accepted word
    function void note_word(logic [15:0] w, logic first, logic last);
      logic [4:0]  n;
      logic [4:0]  cnt;
      int unsigned hw;
      bit          emit;
      verdict_t    v;
      logic [2:0]  slot;
      result_t     r;
      emit = 0;
      v = VERDICT_ACCEPT;
      slot = '0;
      if (first) clear_packet();
      n = word_cnt;
      if (!decided) begin
        case (n)
          WORD_VER_IHL: ver_ihl = w[15:8];
          WORD_FRAG:    frag = w;
          WORD_PROTO:   proto = w[7:0];
          WORD_SRC_HI:  src[31:16] = w;
          WORD_SRC_LO:  src[15:0] = w;
          WORD_DST_HI:  dst[31:16] = w;
          WORD_DST_LO:  dst[15:0] = w;
          default: ;
        endcase
        hw = ver_ihl[3:0] * 2;
        if (n < hw) hdr_sum = hdr_sum + 21'(w);
      end
      cnt = (n < 5'd31) ? n + 5'd1 : 5'd31;
      word_cnt = cnt;
      if (!decided) begin
        hw = ver_ihl[3:0] * 2;
        if (ver_ihl[7:4] != IPV4_VERSION || ver_ihl[3:0] < MIN_IHL) begin
          if (cnt == WORDS_MIN_HDR) begin
            emit = 1;
            v = (ver_ihl[7:4] != IPV4_VERSION) ? VERDICT_VERSION : VERDICT_HDR_LEN;
          end
        end else if (cnt == hw) begin
          emit = 1;
          v = header_verdict(slot);
        end
        if (!emit && last) begin
          emit = 1;
          v = VERDICT_SHORT;
        end
      end
      if (emit) begin
        decided = 1;
        r.verdict = v;
        r.matched_slot = slot;
        r.protocol = proto;
        r.header_bytes = {ver_ihl[3:0], 2'b00};
        r.source_addr = src;
        r.dest_addr = dst;
        expected_verdicts.push_back(r);
      end
      if (last) clear_packet();
    endfunction

    // Compare one verdict word with the oldest prediction
    function void check_verdict(logic [87:0] word);
      result_t got, want;
      got = result_t'(word[83:0]);
      if (expected_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict word %h", word);
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.verdict != want.verdict || got.matched_slot != want.matched_slot ||
          got.protocol != want.protocol || got.header_bytes != want.header_bytes ||
          got.source_addr != want.source_addr || got.dest_addr != want.dest_addr ||
          word[87:84] != '0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("verdict mismatch: exp v=%0d slot=%0d proto=%0d hb=%0d src=%h dst=%h",
                   want.verdict, want.matched_slot, want.protocol, want.header_bytes,
                   want.source_addr, want.dest_addr);
          $display("                  got v=%0d slot=%0d proto=%0d hb=%0d src=%h dst=%h pad=%h",
                   got.verdict, got.matched_slot, got.protocol, got.header_bytes,
                   got.source_addr, got.dest_addr, word[87:84]);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and DUT
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] data_word
  logic        in_tuser = 1'b0; // [0] packet_start
  logic        in_tlast = 1'b0; // packet_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;       // [2:0] verdict, [5:3] matched_slot, [13:6] protocol,
                                // [19:14] header_bytes, [51:20] source_addr,
                                // [83:52] dest_addr, [87:84] zero
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  header_scoreboard sb;
  logic [15:0] pkt[$];
  int          words_sent = 0;
  int          idle_cycles = 0;
  bit          burst = 0;
  logic [31:0] cur_addr0, cur_addr1;
  logic [63:0] cur_codes;

  ipv4_rx_header_check DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: feed accepted words, configuration writes and verdicts to the scoreboard
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_word(in_tdata, in_tuser, in_tlast);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly short gaps, a few long ones, none during a burst
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Verdict sink: random stalls
  initial begin
    int run, stall;
    forever begin
      run = $urandom_range(1, 12);
      stall = burst ? 0 : idle_len();
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drive tasks
  // --------------------------------------------------------------------------
  task automatic push_word(logic [15:0] w, logic first, logic last);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_tuser <= first;
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_packet(bit with_start, bit with_end);
    for (int i = 0; i < pkt.size(); i++)
      push_word(pkt[i], with_start && i == 0, with_end && i == pkt.size() - 1);
  endtask

  task automatic cfg_put(logic [2:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_regs(logic [31:0] a0, logic [31:0] a1, logic [1:0] en,
                              logic [63:0] codes, logic [7:0] valid);
    cur_addr0 = a0;
    cur_addr1 = a1;
    cur_codes = codes;
    cfg_put(CFG_LOCAL_ADDR_0, {32'd0, a0});
    cfg_put(CFG_LOCAL_ADDR_1, {32'd0, a1});
    cfg_put(CFG_LOCAL_ADDR_EN, {62'd0, en});
    cfg_put(CFG_PROTO_CODES, codes);
    cfg_put(CFG_PROTO_SLOT_VALID, {56'd0, valid});
    cfg_valid <= 1'b0;
  endtask

  // Hold the input idle until every verdict is out and the block has settled
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // Build a header into pkt, with a correct checksum when IHL is at least MIN_IHL
  task automatic make_header(logic [3:0] ver, logic [3:0] ihl, logic [15:0] frag_w,
                             logic [7:0] prot, logic [31:0] sa, logic [31:0] da);
    int nw;
    int unsigned s;
    pkt.delete();
    nw = (ihl >= MIN_IHL) ? int'(ihl) * 2 : 10;
    pkt.push_back({ver, ihl, 8'($urandom)});
    pkt.push_back(16'($urandom));
    pkt.push_back(16'($urandom));
    pkt.push_back(frag_w);
    pkt.push_back({8'($urandom), prot});
    pkt.push_back(16'd0);
    pkt.push_back(sa[31:16]);
    pkt.push_back(sa[15:0]);
    pkt.push_back(da[31:16]);
    pkt.push_back(da[15:0]);
    for (int i = 10; i < nw; i++) pkt.push_back(16'($urandom));
    if (ihl >= MIN_IHL) begin
      s = 0;
      for (int i = 0; i < nw; i++) s += pkt[i];
      s = (s & 32'hFFFF) + (s >> 16);
      s = (s & 32'hFFFF) + (s >> 16);
      pkt[5] = ~s[15:0];
    end
  endtask

  task automatic add_payload(int n);
    repeat (n) pkt.push_back(16'($urandom));
  endtask

  // One random packet: mostly well formed, some broken, truncated or noise
  task automatic send_random_packet();
    int          r, cut, n;
    logic [3:0]  ver, ihl;
    logic [15:0] frag_w;
    logic [7:0]  prot;
    logic [31:0] da;
    r = $urandom_range(0, 99);
    ver = IPV4_VERSION;
    ihl = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(6, 15)) : MIN_IHL;
    frag_w = {1'b0, 1'($urandom), 14'd0};
    case ($urandom_range(0, 9))
      0: frag_w[FLAG_MF_BIT] = 1'b1;
      1: frag_w[FRAG_OFS_W-1:0] = 13'($urandom);
      default: ;
    endcase
    prot = ($urandom_range(0, 3) != 0) ? cur_codes[8*$urandom_range(0, 7) +: 8]
                                       : 8'($urandom);
    if ($urandom_range(0, 9) < 7) da = $urandom_range(0, 1) ? cur_addr1 : cur_addr0;
    else da = $urandom;
    if (r < 8) begin
      ver = 4'($urandom);
      if (ver == IPV4_VERSION) ver = ~ver;
    end else if (r < 16) begin
      ihl = 4'($urandom_range(0, 4));
    end
    make_header(ver, ihl, frag_w, prot, $urandom, da);
    add_payload($urandom_range(0, 6));
    if (r >= 16 && r < 22)
      pkt[$urandom_range(0, int'(ihl) * 2 - 1)] ^= 16'(1 << $urandom_range(0, 15));
    if (r >= 22 && r < 30) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
    if (r >= 30 && r < 35) begin
      // no start marker: relies on the previous end having cleared state
      send_packet(0, 1);
    end else if (r >= 35 && r < 40) begin
      // abandon mid-header; the next start restarts the packet
      cut = $urandom_range(1, 9);
      while (pkt.size() > cut) void'(pkt.pop_back());
      send_packet(1, 0);
    end else if (r >= 40 && r < 45) begin
      n = $urandom_range(1, 12);
      repeat (n) push_word(16'($urandom), $urandom_range(0, 3) == 0,
                           $urandom_range(0, 3) == 0);
    end else begin
      send_packet(1, 1);
    end
  endtask

  // Random traffic until the word budget is spent, closed by a clean packet
  task automatic random_phase(int budget);
    int stop;
    stop = words_sent + budget;
    while (words_sent < stop) begin
      if ($urandom_range(0, 7) == 0) burst = ($urandom_range(0, 3) == 0);
      send_random_packet();
    end
    burst = 0;
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, cur_codes[7:0], $urandom, cur_addr0);
    send_packet(1, 1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] a0, a1;
    a0 = 32'h0A000001;
    a1 = 32'hC0A80001;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: slot 0 and 3 hold TCP, slot 2 (ICMP) disabled, slot 7 is 0xFF
    program_regs(a0, a1, 2'b11, 64'hFF00_0000_0601_1106, 8'b1000_1011);
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd6, 32'hFFFFFFFF, a0);
    add_payload(2);
    send_packet(1, 1);
    make_header(IPV4_VERSION, 4'd6, 16'h4000, 8'd17, 32'h0, a1);
    add_payload(1);
    send_packet(1, 1);
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd1, 32'h01020304, a0);
    send_packet(1, 1);
    make_header(IPV4_VERSION, MIN_IHL, 16'hC000, 8'hFF, 32'h05060708, a1);
    send_packet(1, 1);
    // bad checksum
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd6, 32'h11111111, a0);
    pkt[5] ^= 16'h0001;
    send_packet(1, 1);
    // destination not local
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd6, 32'h22222222, 32'h0A000002);
    send_packet(1, 1);
    // fragments: more-fragments flag, then largest offset
    make_header(IPV4_VERSION, MIN_IHL, 16'h2000, 8'd6, 32'h33333333, a0);
    send_packet(1, 1);
    make_header(IPV4_VERSION, MIN_IHL, 16'h1FFF, 8'd6, 32'h44444444, a0);
    send_packet(1, 1);
    // early decisions: bad version, short IHL, both (version wins)
    make_header(4'd6, MIN_IHL, 16'd0, 8'd6, 32'h55555555, a0);
    add_payload(3);
    send_packet(1, 1);
    make_header(IPV4_VERSION, 4'd4, 16'd0, 8'd6, 32'h66666666, a0);
    send_packet(1, 1);
    make_header(4'd0, 4'd0, 16'd0, 8'd6, 32'h77777777, a0);
    send_packet(1, 1);
    // short packets: before ten words, and before a long header completes
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd6, 32'h88888888, a0);
    while (pkt.size() > 3) void'(pkt.pop_back());
    send_packet(1, 1);
    make_header(IPV4_VERSION, 4'd8, 16'd0, 8'd6, 32'h99999999, a0);
    while (pkt.size() > 12) void'(pkt.pop_back());
    send_packet(1, 1);
    // restart mid-packet, then a packet with no start marker
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd6, 32'hAAAAAAAA, a0);
    while (pkt.size() > 5) void'(pkt.pop_back());
    send_packet(1, 0);
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd17, 32'hBBBBBBBB, a1);
    send_packet(1, 1);
    make_header(IPV4_VERSION, MIN_IHL, 16'd0, 8'd6, 32'hCCCCCCCC, a0);
    send_packet(0, 1);
    // single-word packets at both data extremes
    push_word(16'hFFFF, 1'b1, 1'b1);
    push_word(16'h0000, 1'b1, 1'b1);
    // longest header
    make_header(IPV4_VERSION, 4'd15, 16'd0, 8'd6, 32'hDDDDDDDD, a0);
    send_packet(1, 1);
    random_phase(180);

    // All-ones registers
    wait_idle();
    program_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 2'b11, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF);
    random_phase(150);

    // All-zero registers: nothing local, nothing registered
    wait_idle();
    program_regs(32'h0, 32'h0, 2'b00, 64'h0, 8'h00);
    random_phase(110);

    // Random settings
    repeat (2) begin
      wait_idle();
      program_regs($urandom, $urandom, 2'($urandom_range(1, 3)),
                   {$urandom, $urandom}, 8'($urandom));
      random_phase(140);
    end

    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: ipv4_rx_header_check.f
src/ihr_pkg.sv
src/ihr_front.sv
src/ihr_queue.sv
src/ihr_back.sv
src/ipv4_rx_header_check.sv
test/tb.sv
